### rtl/core/bsa_pkg.sv
// Shared types, constants and helper functions for the bitmap slot allocator.
// Used by bsa_front, bsa_back and bitmap_slot_allocator; no dependencies.
`default_nettype none

package bsa_pkg;

    // Geometry of the slot bitmap
    localparam int NUM_SLOTS = 1024;
    localparam int WORD_W    = 32;
    localparam int NUM_WORDS = NUM_SLOTS / WORD_W;
    localparam int WIDX_W    = $clog2(NUM_WORDS);
    localparam int BIT_W     = $clog2(WORD_W);
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int SIZE_W    = SLOT_W + 1;
    localparam int IDX_W     = 16;
    localparam int CNT_W     = WIDX_W + 1;

    localparam logic [SIZE_W-1:0] SIZE_MIN = SIZE_W'(2);
    localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(NUM_SLOTS);

    // Request kinds carried in tuser
    typedef enum logic [1:0] {
        MODE_ALLOC   = 2'd0,
        MODE_RELEASE = 2'd1,
        MODE_QUERY   = 2'd2,
        MODE_CHECK   = 2'd3
    } t_mode;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_RANGE   = 3'd2,
        ST_ALREADY = 3'd3,
        ST_IS_FREE = 3'd4
    } t_status;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_EXEC = 2'd1,
        BK_SCAN = 2'd2
    } t_bk_state;

    // Classified request passed from the front to the back
    typedef struct packed {
        t_mode             mode;
        logic [SLOT_W-1:0] slot;
        logic              in_range;
        logic              is_zero;
    } t_req;

    // Bring a written size into the legal range
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        if (v < SIZE_MIN) begin
            r = SIZE_MIN;
        end else if (v > SIZE_MAX) begin
            r = SIZE_MAX;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Free bits of one bitmap word straight after initialisation
    function automatic logic [WORD_W-1:0] reset_row(input logic [WIDX_W-1:0] w,
                                                    input logic [SIZE_W-1:0] size);
        logic [WORD_W-1:0] r;
        logic [SIZE_W-1:0] idx;
        for (int b = 0; b < WORD_W; b++) begin
            idx  = {1'b0, w, BIT_W'(b)};
            r[b] = (idx >= SIZE_MIN) && (idx < size);
        end
        return r;
    endfunction

    // Position of the lowest set bit (zero when none is set)
    function automatic logic [BIT_W-1:0] lowest_one(input logic [WORD_W-1:0] v);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (v[b]) begin
                r = BIT_W'(b);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/bsa_front.sv
// Front end of the slot allocator: accepts requests, classifies them and queues them.
// Depends on bsa_pkg for the request struct and bitmap geometry.
`default_nettype none

module bsa_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // Incoming request transaction
    input  wire logic                       i_s_tvalid,
    output      logic                       o_s_tready,
    input  wire logic [bsa_pkg::IDX_W-1:0]  i_slot_number,
    input  wire logic [1:0]                 i_mode,
    // Current table size, for the range check
    input  wire logic [bsa_pkg::SIZE_W-1:0] i_size,
    // Queue head towards the back end
    output      logic                       o_req_vld,
    output      bsa_pkg::t_req              o_req,
    input  wire logic                       i_req_pop
);

    bsa_pkg::t_req r_q [0:1];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic          w_push;
    bsa_pkg::t_req w_new;

    // Classify the incoming request
    always_comb begin
        w_new.mode     = bsa_pkg::t_mode'(i_mode);
        w_new.slot     = i_slot_number[bsa_pkg::SLOT_W-1:0];
        w_new.in_range = i_slot_number < bsa_pkg::IDX_W'(i_size);
        w_new.is_zero  = (i_slot_number == '0);
    end

    assign o_s_tready = (r_cnt != 2'd2);
    assign w_push     = i_s_tvalid && o_s_tready;
    assign o_req_vld  = (r_cnt != 2'd0);
    assign o_req      = r_q[r_rp];

    // Store the classified request
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_new;
        end
    end

    // Advance the queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_req_pop) begin
                r_rp <= ~r_rp;
            end
            if (w_push && !i_req_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!w_push && i_req_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/bsa_back.sv
// Back end of the slot allocator: bitmap RAM, next-fit scan, release/query/check
// and the result register. Depends on bsa_pkg.
`default_nettype none

module bsa_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // Size register write
    input  wire logic                       i_cfg_we,
    input  wire logic [bsa_pkg::SIZE_W-1:0] i_cfg_wdata,
    output      logic [bsa_pkg::SIZE_W-1:0] o_size,
    // Queue head from the front end
    input  wire logic                       i_req_vld,
    input  wire bsa_pkg::t_req              i_req,
    output      logic                       o_req_pop,
    // Result transaction
    output      logic                       o_m_tvalid,
    input  wire logic                       i_m_tready,
    output      logic [bsa_pkg::SLOT_W-1:0] o_granted_slot,
    output      bsa_pkg::t_status           o_status,
    output      logic                       o_slot_free,
    output      logic [bsa_pkg::SIZE_W-1:0] o_free_total
);

    localparam int WW = bsa_pkg::WORD_W;
    localparam int AW = bsa_pkg::WIDX_W;
    localparam int BW = bsa_pkg::BIT_W;
    localparam int SW = bsa_pkg::SLOT_W;
    localparam int ZW = bsa_pkg::SIZE_W;
    localparam int CW = bsa_pkg::CNT_W;

    // Sequencer and architectural state
    bsa_pkg::t_bk_state              r_state, n_state;
    logic [ZW-1:0]                   r_size;
    logic [SW-1:0]                   r_start, n_start;
    logic [ZW-1:0]                   r_free_cnt, n_free_cnt;
    logic [bsa_pkg::NUM_WORDS-1:0]   r_row_vld;
    bsa_pkg::t_req                   r_req;

    // Bitmap RAM
    logic [WW-1:0] r_mem [0:bsa_pkg::NUM_WORDS-1];
    logic [WW-1:0] r_rdata;
    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr;
    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    logic [WW-1:0] w_wr_data;

    // Scan issue and evaluate stages
    logic [AW-1:0] r_iss_w, n_iss_w;
    logic [CW-1:0] r_iss_cnt, n_iss_cnt;
    logic          r_p_vld, n_p_vld;
    logic [AW-1:0] r_p_w;
    logic [WW-1:0] r_p_mask, n_p_mask;
    logic          r_p_last, n_p_last;
    logic          w_issue;

    // Result register
    logic                r_o_vld;
    logic [SW-1:0]       r_o_granted, n_o_granted;
    bsa_pkg::t_status    r_o_status, n_o_status;
    logic                r_o_free, n_o_free;
    logic [ZW-1:0]       r_o_total;
    logic                w_o_load;

    // Derived values
    logic [ZW-1:0] w_size_m1;
    logic [AW-1:0] w_last_w;
    logic [CW-1:0] w_visits;
    logic [AW-1:0] w_eval_w;
    logic [WW-1:0] w_word;
    logic [WW-1:0] w_hits;
    logic [BW-1:0] w_hit_bit;
    logic [SW-1:0] w_hit_slot;
    logic [BW-1:0] w_rel_bit;
    logic          w_bit_free;
    logic          w_found;
    logic          w_full;
    logic          w_pop;
    logic          w_out_room;

    assign w_size_m1 = r_size - ZW'(1);
    assign w_last_w  = w_size_m1[SW-1:BW];
    assign w_visits  = {1'b0, w_last_w} + CW'(2);
    assign w_eval_w  = (r_state == bsa_pkg::BK_EXEC) ? r_req.slot[SW-1:BW] : r_p_w;
    // A row never written since initialisation reads as its initial pattern
    assign w_word    = r_row_vld[w_eval_w] ? r_rdata : bsa_pkg::reset_row(w_eval_w, r_size);
    assign w_hits    = w_word & r_p_mask;
    assign w_hit_bit = bsa_pkg::lowest_one(w_hits);
    assign w_hit_slot = {r_p_w, w_hit_bit};
    assign w_rel_bit = r_req.slot[BW-1:0];
    assign w_bit_free = w_word[w_rel_bit];
    assign w_found   = (r_state == bsa_pkg::BK_SCAN) && r_p_vld && (w_hits != '0);
    assign w_full    = (r_state == bsa_pkg::BK_SCAN) && r_p_vld && (w_hits == '0) && r_p_last;
    assign w_out_room = !r_o_vld || i_m_tready;
    assign w_pop     = (r_state == bsa_pkg::BK_IDLE) && i_req_vld && w_out_room && !i_cfg_we;
    assign w_issue   = (r_state == bsa_pkg::BK_SCAN) && !w_found && !w_full
                       && (r_iss_cnt < w_visits);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bsa_pkg::BK_IDLE: begin
                if (w_pop) begin
                    n_state = (i_req.mode == bsa_pkg::MODE_ALLOC) ? bsa_pkg::BK_SCAN
                                                                  : bsa_pkg::BK_EXEC;
                end
            end
            bsa_pkg::BK_EXEC: begin
                n_state = bsa_pkg::BK_IDLE;
            end
            bsa_pkg::BK_SCAN: begin
                if (w_found || w_full) begin
                    n_state = bsa_pkg::BK_IDLE;
                end
            end
            default: n_state = bsa_pkg::BK_IDLE;
        endcase
    end

    // Datapath controls and result
    always_comb begin
        w_rd_en     = 1'b0;
        w_rd_addr   = r_iss_w;
        w_wr_en     = 1'b0;
        w_wr_addr   = w_eval_w;
        w_wr_data   = w_word;
        n_start     = r_start;
        n_free_cnt  = r_free_cnt;
        n_iss_w     = r_iss_w;
        n_iss_cnt   = r_iss_cnt;
        n_p_vld     = 1'b0;
        n_p_mask    = '1;
        n_p_last    = 1'b0;
        w_o_load    = 1'b0;
        n_o_granted = '0;
        n_o_status  = bsa_pkg::ST_OK;
        n_o_free    = 1'b0;
        unique case (r_state)
            bsa_pkg::BK_IDLE: begin
                // Fetch the addressed word, or prime the scan from the search start
                if (w_pop) begin
                    w_rd_en   = (i_req.mode != bsa_pkg::MODE_ALLOC);
                    w_rd_addr = i_req.slot[SW-1:BW];
                    n_iss_w   = r_start[SW-1:BW];
                    n_iss_cnt = '0;
                end
            end
            bsa_pkg::BK_EXEC: begin
                w_o_load = 1'b1;
                unique case (r_req.mode)
                    bsa_pkg::MODE_RELEASE: begin
                        if (r_req.is_zero || !r_req.in_range) begin
                            n_o_status = bsa_pkg::ST_RANGE;
                        end else if (w_bit_free) begin
                            n_o_status = bsa_pkg::ST_ALREADY;
                        end else begin
                            w_wr_en    = 1'b1;
                            w_wr_data  = w_word | (WW'(1) << w_rel_bit);
                            n_free_cnt = r_free_cnt + ZW'(1);
                        end
                    end
                    bsa_pkg::MODE_QUERY: begin
                        if (!r_req.in_range) begin
                            n_o_status = bsa_pkg::ST_RANGE;
                        end else begin
                            n_o_free = w_bit_free;
                        end
                    end
                    bsa_pkg::MODE_CHECK: begin
                        if (!r_req.in_range) begin
                            n_o_status = bsa_pkg::ST_RANGE;
                        end else if (w_bit_free) begin
                            n_o_status = bsa_pkg::ST_IS_FREE;
                        end
                    end
                    bsa_pkg::MODE_ALLOC: begin
                        n_o_status = bsa_pkg::ST_FULL;
                    end
                    default: n_o_status = bsa_pkg::ST_OK;
                endcase
            end
            bsa_pkg::BK_SCAN: begin
                // Claim the lowest free bit of the word under evaluation
                if (w_found) begin
                    w_o_load    = 1'b1;
                    n_o_granted = w_hit_slot;
                    w_wr_en     = 1'b1;
                    w_wr_data   = w_word & ~(WW'(1) << w_hit_bit);
                    n_free_cnt  = r_free_cnt - ZW'(1);
                    n_start     = (({1'b0, w_hit_slot} + ZW'(1)) == r_size) ? '0
                                  : w_hit_slot + SW'(1);
                end else if (w_full) begin
                    w_o_load   = 1'b1;
                    n_o_status = bsa_pkg::ST_FULL;
                end
                // Issue the next word: first visit masks below the start, last at and above it
                if (w_issue) begin
                    w_rd_en   = 1'b1;
                    n_p_vld   = 1'b1;
                    n_p_last  = (r_iss_cnt == w_visits - CW'(1));
                    if (r_iss_cnt == '0) begin
                        n_p_mask = {WW{1'b1}} << r_start[BW-1:0];
                    end else if (n_p_last) begin
                        n_p_mask = ~({WW{1'b1}} << r_start[BW-1:0]);
                    end
                    n_iss_w   = (r_iss_w == w_last_w) ? '0 : r_iss_w + AW'(1);
                    n_iss_cnt = r_iss_cnt + CW'(1);
                end
            end
            default: begin
                w_rd_en = 1'b0;
            end
        endcase
    end

    // Bitmap RAM with registered read
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_req <= i_req;
        end
        r_iss_w   <= n_iss_w;
        r_iss_cnt <= n_iss_cnt;
        if (w_issue) begin
            r_p_w    <= r_iss_w;
            r_p_mask <= n_p_mask;
            r_p_last <= n_p_last;
        end
        if (w_o_load) begin
            r_o_granted <= n_o_granted;
            r_o_status  <= n_o_status;
            r_o_free    <= n_o_free;
            r_o_total   <= n_free_cnt;
        end
    end

    // Control and architectural state; a size write reinitialises the table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= bsa_pkg::BK_IDLE;
            r_size     <= bsa_pkg::SIZE_MAX;
            r_start    <= SW'(1);
            r_free_cnt <= bsa_pkg::SIZE_MAX - ZW'(2);
            r_row_vld  <= '0;
            r_p_vld    <= 1'b0;
            r_o_vld    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_p_vld <= n_p_vld;
            if (i_cfg_we) begin
                r_size     <= bsa_pkg::clamp_size(i_cfg_wdata);
                r_start    <= SW'(1);
                r_free_cnt <= bsa_pkg::clamp_size(i_cfg_wdata) - ZW'(2);
                r_row_vld  <= '0;
            end else begin
                r_start    <= n_start;
                r_free_cnt <= n_free_cnt;
                if (w_wr_en) begin
                    r_row_vld[w_wr_addr] <= 1'b1;
                end
            end
            if (w_o_load) begin
                r_o_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    assign o_size         = r_size;
    assign o_req_pop      = w_pop;
    assign o_m_tvalid     = r_o_vld;
    assign o_granted_slot = r_o_granted;
    assign o_status       = r_o_status;
    assign o_slot_free    = r_o_free;
    assign o_free_total   = r_o_total;

    // Free count never exceeds the number of releasable slots
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_cnt <= r_size - ZW'(1))
        else $error("free count above table size");

    // Search start stays inside the table
    a_start_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ZW'(r_start) < r_size)
        else $error("search start outside table");

    // A successful allocation never grants the reserved slot
    a_grant_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_found |-> (w_hit_slot != '0))
        else $error("reserved slot granted");

    // A result is only produced while the result register is free to take it
    a_out_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_o_load |-> !r_o_vld || $past(i_m_tready) || !$past(r_o_vld))
        else $error("result register overwritten");

    // Scan never issues beyond its word budget
    a_scan_budget: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bsa_pkg::BK_SCAN) |-> (r_iss_cnt <= w_visits))
        else $error("scan overran its word budget");

endmodule

`default_nettype wire

### rtl/core/bitmap_slot_allocator.sv
// Next-fit bitmap slot allocator, top level.
// Depends on bsa_pkg, bsa_front and bsa_back.
//
// Usage:
//   Requests enter on the slave stream: tuser carries the request kind
//   (allocate, release, query, check) and tdata the 16-bit slot number.
//   Each request yields exactly one result transaction on the master stream.
//   The size register is written through i_cfg_we/i_cfg_wdata while the block
//   is idle; a write reinitialises the bitmap, search start and free count.
// Sequencing and throughput:
//   Release, query and check take one RAM read and one evaluate/write step in
//   the back end. Allocate reads one 32-bit bitmap word per cycle from the
//   bitmap RAM, pipelined behind its registered read.
//   A two-entry request queue lets the input side keep accepting meanwhile.
// Reset:
//   Synchronous, active low. Size returns to 1024, all slots from 2 upward are
//   free, the search start is 1 and no clearing pass is needed.
// Back-pressure:
//   The result register holds while o_m_axis_tvalid is high and
//   i_m_axis_tready low; the back end then stops taking requests and the queue
//   fills, after which o_s_axis_tready falls.
`default_nettype none

module bitmap_slot_allocator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Size register
    input  wire logic        i_cfg_we,
    input  wire logic [10:0] i_cfg_wdata,      // slots_in_use
    // Request stream
    input  wire logic        i_s_axis_tvalid,
    output      logic        o_s_axis_tready,
    input  wire logic [15:0] i_s_axis_tdata,   // [15:0] slot_number
    input  wire logic [1:0]  i_s_axis_tuser,   // [1:0] mode
    // Result stream
    output      logic        o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [9:0] granted_slot, [12:10] status, [13] slot_free, [24:14] free_total, [31:25] zero
    output      logic [31:0] o_m_axis_tdata
);

    logic [bsa_pkg::SIZE_W-1:0] w_size;
    logic                       w_req_vld;
    bsa_pkg::t_req              w_req;
    logic                       w_req_pop;
    logic [bsa_pkg::SLOT_W-1:0] w_granted;
    bsa_pkg::t_status           w_status;
    logic                       w_slot_free;
    logic [bsa_pkg::SIZE_W-1:0] w_free_total;

    // Accept and classify requests
    bsa_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_axis_tvalid),
        .o_s_tready    (o_s_axis_tready),
        .i_slot_number (i_s_axis_tdata),
        .i_mode        (i_s_axis_tuser),
        .i_size        (w_size),
        .o_req_vld     (w_req_vld),
        .o_req         (w_req),
        .i_req_pop     (w_req_pop)
    );

    // Carry out requests against the bitmap
    bsa_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_size         (w_size),
        .i_req_vld      (w_req_vld),
        .i_req          (w_req),
        .o_req_pop      (w_req_pop),
        .o_m_tvalid     (o_m_axis_tvalid),
        .i_m_tready     (i_m_axis_tready),
        .o_granted_slot (w_granted),
        .o_status       (w_status),
        .o_slot_free    (w_slot_free),
        .o_free_total   (w_free_total)
    );

    // Pack the result fields
    assign o_m_axis_tdata = {7'd0, w_free_total, w_slot_free, w_status, w_granted};

endmodule

`default_nettype wire

### dv/tb_bitmap_slot_allocator.sv
`timescale 1ns / 100ps
// Testbench for bitmap_slot_allocator: directed and random request streams, each
// result checked against an in-bench model of the next-fit bitmap. Depends on bsa_pkg.

module tb_bitmap_slot_allocator;

    localparam int QUIET_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS  = 145;
    localparam int NUM_PHASES   = 12;

    typedef struct packed {
        bsa_pkg::t_mode mode;
        logic [15:0]    slot;
    } t_slot_req;

    typedef struct packed {
        logic [9:0]       granted;
        bsa_pkg::t_status status;
        logic             slot_free;
        logic [10:0]      free_total;
    } t_slot_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [10:0] i_cfg_wdata = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata = '0;   // [15:0] slot_number
    logic [1:0]  i_s_axis_tuser = '0;   // [1:0] mode
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    // [9:0] granted_slot, [12:10] status, [13] slot_free, [24:14] free_total
    logic [31:0] o_m_axis_tdata;

    // Bitmap model: 1 marks a free slot
    logic        slot_map [bsa_pkg::NUM_SLOTS];
    int unsigned managed_size;
    int unsigned next_start;
    int unsigned free_count;

    t_slot_req    request_q [$];
    t_slot_result pending_results [$];

    int errors = 0;
    int sent = 0;
    int checked = 0;
    int size_writes = 0;
    int status_seen [5] = '{default: 0};

    // Sender burst and receiver stall state
    int burst_left = 1;
    int gap_left = 0;
    int rx_mode = 0;
    int rx_cycle = 0;
    int stall_left = 0;
    int quiet_cycles = 0;

    bitmap_slot_allocator u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Rebuild the bitmap for a newly written size, clamped to the legal range
    function automatic void reinit_map(input logic [10:0] written);
        int unsigned v;
        v = written;
        if (v < 2) begin
            v = 2;
        end else if (v > bsa_pkg::NUM_SLOTS) begin
            v = bsa_pkg::NUM_SLOTS;
        end
        managed_size = v;
        for (int i = 0; i < bsa_pkg::NUM_SLOTS; i++) begin
            slot_map[i] = (i >= 2) && (i < v);
        end
        next_start = 1;
        free_count = v - 2;
    endfunction

    // Apply one request to the bitmap model and return the result it should give
    function automatic t_slot_result allocator_step(input t_slot_req req);
        t_slot_result r;
        int unsigned  first;
        int unsigned  pick;
        int unsigned  i;
        logic         found;
        logic         in_range;
        r        = '0;
        in_range = req.slot < managed_size;
        found    = 1'b0;
        pick     = 0;
        case (req.mode)
            bsa_pkg::MODE_ALLOC: begin
                // Next fit: from the search start to the end, then wrap to slot 1
                first = next_start;
                for (i = first; i < managed_size && !found; i++) begin
                    if (slot_map[i]) begin
                        found = 1'b1;
                        pick  = i;
                    end
                end
                for (i = 1; i < first && !found; i++) begin
                    if (slot_map[i]) begin
                        found = 1'b1;
                        pick  = i;
                    end
                end
                if (found) begin
                    slot_map[pick] = 1'b0;
                    free_count--;
                    next_start = (pick + 1) % managed_size;
                    r.granted  = 10'(pick);
                end else begin
                    r.status = bsa_pkg::ST_FULL;
                end
            end
            bsa_pkg::MODE_RELEASE: begin
                if (req.slot == 0 || !in_range) begin
                    r.status = bsa_pkg::ST_RANGE;
                end else if (slot_map[req.slot]) begin
                    r.status = bsa_pkg::ST_ALREADY;
                end else begin
                    slot_map[req.slot] = 1'b1;
                    free_count++;
                end
            end
            bsa_pkg::MODE_QUERY: begin
                if (!in_range) begin
                    r.status = bsa_pkg::ST_RANGE;
                end else begin
                    r.slot_free = slot_map[req.slot];
                end
            end
            default: begin
                if (!in_range) begin
                    r.status = bsa_pkg::ST_RANGE;
                end else if (slot_map[req.slot]) begin
                    r.status = bsa_pkg::ST_IS_FREE;
                end
            end
        endcase
        r.free_total = 11'(free_count);
        return r;
    endfunction

    function automatic void push_req(input bsa_pkg::t_mode m, input logic [15:0] s);
        request_q.push_back('{mode: m, slot: s});
    endfunction

    // Random request: mostly slots near the managed range, some anywhere in 16 bits
    function automatic void push_random_req(input int unsigned alloc_pct);
        t_slot_req   q;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < alloc_pct) begin
            q.mode = bsa_pkg::MODE_ALLOC;
        end else begin
            pick = $urandom_range(0, 3);
            q.mode = (pick < 2) ? bsa_pkg::MODE_RELEASE
                   : ((pick == 2) ? bsa_pkg::MODE_QUERY : bsa_pkg::MODE_CHECK);
        end
        if ($urandom_range(0, 6) == 0) begin
            q.slot = 16'($urandom);
        end else begin
            q.slot = 16'($urandom_range(0, managed_size + 1));
        end
        request_q.push_back(q);
    endfunction

    // Hold until every request is sent and every result is back, then let the block settle
    task automatic wait_drained();
        while (request_q.size() != 0 || pending_results.size() != 0 || i_s_axis_tvalid) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_size(input logic [10:0] v);
        wait_drained();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        reinit_map(v);
        size_writes++;
    endtask

    // Sender: bursts of random length with random gaps, valid held until accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                pending_results.push_back(allocator_step(request_q.pop_front()));
                sent++;
            end
            if (i_s_axis_tvalid && !o_s_axis_tready) begin
                // hold the offered transaction
            end else if (gap_left != 0) begin
                gap_left--;
                i_s_axis_tvalid <= 1'b0;
            end else if (request_q.size() != 0) begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= request_q[0].slot;
                i_s_axis_tuser  <= request_q[0].mode;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Compare one result transaction with the oldest expectation
    task automatic check_result(input logic [31:0] d);
        t_slot_result want;
        if (pending_results.size() == 0) begin
            $display("%0t: result %h arrived with nothing expected", $time, d);
            errors++;
        end else begin
            want = pending_results.pop_front();
            checked++;
            status_seen[want.status]++;
            if (d[9:0] !== want.granted) begin
                $display("%0t: granted_slot expected %0d actual %0d", $time, want.granted,
                         d[9:0]);
                errors++;
            end
            if (d[12:10] !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, d[12:10]);
                errors++;
            end
            if (d[13] !== want.slot_free) begin
                $display("%0t: slot_free expected %0d actual %0d", $time, want.slot_free, d[13]);
                errors++;
            end
            if (d[24:14] !== want.free_total) begin
                $display("%0t: free_total expected %0d actual %0d", $time, want.free_total,
                         d[24:14]);
                errors++;
            end
            if (d[31:25] !== 7'd0) begin
                $display("%0t: padding expected 0 actual %h", $time, d[31:25]);
                errors++;
            end
        end
    endtask

    // Receiver: check accepted results and stall on a randomly chosen pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                check_result(o_m_axis_tdata);
            end
            rx_cycle++;
            if (rx_cycle % 300 == 0) begin
                rx_mode = $urandom_range(0, 3);
            end
            if (stall_left != 0) begin
                stall_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                case (rx_mode)
                    0: i_m_axis_tready <= 1'b1;
                    1: i_m_axis_tready <= ($urandom_range(0, 3) != 0);
                    2: i_m_axis_tready <= (rx_cycle % 8 < 3);
                    default: begin
                        i_m_axis_tready <= 1'b1;
                        if ($urandom_range(0, 15) == 0) begin
                            stall_left = $urandom_range(1, 40);
                        end
                    end
                endcase
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Stimulus: directed cases, then random phases at several sizes
    initial begin
        int unsigned phase_size [NUM_PHASES];
        int unsigned alloc_pct [NUM_PHASES];
        int unsigned sz;
        phase_size = '{64, 1024, 33, 0, 32, 2047, 31, 3, 1023, 100, 5, 0};
        alloc_pct  = '{75, 55, 50, 50, 70, 60, 45, 50, 65, 50, 50, 55};
        reinit_map(11'd1024);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset size: allocate, release edge slots, root, query and check corners
        push_req(bsa_pkg::MODE_ALLOC, 16'hFFFF);
        push_req(bsa_pkg::MODE_ALLOC, 16'h0000);
        push_req(bsa_pkg::MODE_RELEASE, 16'd0);
        push_req(bsa_pkg::MODE_RELEASE, 16'd1);
        push_req(bsa_pkg::MODE_RELEASE, 16'd1);
        push_req(bsa_pkg::MODE_RELEASE, 16'd1023);
        push_req(bsa_pkg::MODE_RELEASE, 16'd1024);
        push_req(bsa_pkg::MODE_QUERY, 16'd0);
        push_req(bsa_pkg::MODE_QUERY, 16'd1);
        push_req(bsa_pkg::MODE_QUERY, 16'hFFFF);
        push_req(bsa_pkg::MODE_CHECK, 16'd0);
        push_req(bsa_pkg::MODE_CHECK, 16'd1);
        push_req(bsa_pkg::MODE_CHECK, 16'd2);
        push_req(bsa_pkg::MODE_CHECK, 16'd1024);
        push_req(bsa_pkg::MODE_ALLOC, 16'd0);

        // Size below the minimum: table full, root released and reclaimed
        write_size(11'd0);
        push_req(bsa_pkg::MODE_ALLOC, 16'd0);
        push_req(bsa_pkg::MODE_RELEASE, 16'd1);
        push_req(bsa_pkg::MODE_ALLOC, 16'd0);
        push_req(bsa_pkg::MODE_ALLOC, 16'd0);
        push_req(bsa_pkg::MODE_QUERY, 16'd1);
        push_req(bsa_pkg::MODE_CHECK, 16'd1);

        // Three slots: claiming the last slot wraps the search start to zero
        write_size(11'd3);
        push_req(bsa_pkg::MODE_ALLOC, 16'd0);
        push_req(bsa_pkg::MODE_RELEASE, 16'd2);
        push_req(bsa_pkg::MODE_ALLOC, 16'd0);

        for (int p = 0; p < NUM_PHASES; p++) begin
            sz = (p == NUM_PHASES - 1) ? $urandom_range(2, bsa_pkg::NUM_SLOTS)
                                       : phase_size[p];
            write_size(11'(sz));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                push_random_req(alloc_pct[p]);
            end
        end

        wait_drained();
        $display("%0d requests sent and %0d results compared over %0d size settings",
                 sent, checked, size_writes);
        $display("statuses: ok %0d, full %0d, out of range %0d, already free %0d, free %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/bsa_pkg.sv
rtl/core/bsa_front.sv
rtl/core/bsa_back.sv
rtl/core/bitmap_slot_allocator.sv
dv/tb_bitmap_slot_allocator.sv
